### rtl/idg_pkg.sv
// Shared types and constants for the index stream delta gate.
package idg_pkg;

   localparam int COUNT_BITS   = 32;
   localparam int VALUE_BITS   = 16;
   localparam int BYTE_BITS    = 8;
   localparam int SUM_BITS     = 48;
   localparam int CHG_BITS     = 32;
   localparam int BIN_BITS     = 32;
   localparam int SMALL_BINS   = 16;
   localparam int BIN_IDX_BITS = $clog2(SMALL_BINS);
   localparam int ACC_BITS     = BIN_BITS + BIN_IDX_BITS;
   localparam int PROD_BITS    = VALUE_BITS + COUNT_BITS;
   localparam int CMP_BITS     = (SUM_BITS + 6 > PROD_BITS) ? SUM_BITS + 6 : PROD_BITS;

   localparam int N_MIN_W1     = 64;
   localparam int RANGE_MIN_W1 = 64;
   localparam int N_MIN_BINS   = 16384;
   localparam int N_MIN_W2     = 10000;
   localparam int RANGE_MIN_W2 = 200;
   localparam int RANGE_WIDE_W2 = 500;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 4;
   localparam int WIDTH_BITS     = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IS_NUMERIC    = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ELEMENT_WIDTH = 1'd1;

   localparam logic [WIDTH_BITS-1:0] WIDTH_BYTE = 4'd1;
   localparam logic [WIDTH_BITS-1:0] WIDTH_HALF = 4'd2;

   typedef struct packed {
      logic update;
      logic prep;
      logic mult;
      logic bin_step;
      logic compare;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic bin_last;
   } dp_status_type;

endpackage

### rtl/idg_if.sv
// Request and response channel interfaces of the index stream delta gate.
interface idg_req_if;
   logic                           valid;
   logic                           ready;
   logic [idg_pkg::VALUE_BITS-1:0] element_value;
   logic                           last_element;

   modport source (output valid, output element_value, output last_element, input ready);
   modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

interface idg_rsp_if;
   logic valid;
   logic ready;
   logic choose_delta;

   modport source (output valid, output choose_delta, input ready);
   modport sink   (input valid, input choose_delta, output ready);
endinterface

### rtl/idg_datapath.sv
// Statistics registers, decision arithmetic and result register of the delta gate.
module idg_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  idg_pkg::ctl_cmd_type               cmd,
   output idg_pkg::dp_status_type             status,
   input  logic                               csr_write_enable,
   input  logic [idg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [idg_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic [idg_pkg::VALUE_BITS-1:0]     element_value,
   output logic                               choose_delta
);

   logic                             numeric_ff, numeric_in;
   logic [idg_pkg::WIDTH_BITS-1:0]   width_ff, width_in;

   logic [idg_pkg::COUNT_BITS-1:0]   count_ff, count_in;
   logic [idg_pkg::VALUE_BITS-1:0]   prev_ff, prev_in;
   logic [idg_pkg::VALUE_BITS-1:0]   min_ff, min_in;
   logic [idg_pkg::VALUE_BITS-1:0]   max_ff, max_in;
   logic [idg_pkg::SUM_BITS-1:0]     dsum_ff, dsum_in;
   logic [idg_pkg::CHG_BITS-1:0]     chg_ff, chg_in;
   logic [idg_pkg::BIN_BITS-1:0]     bins_ff [idg_pkg::SMALL_BINS];
   logic [idg_pkg::BIN_BITS-1:0]     bins_in [idg_pkg::SMALL_BINS];

   logic [idg_pkg::VALUE_BITS-1:0]   range_ff, range_in;
   logic [idg_pkg::COUNT_BITS-1:0]   nm1_ff, nm1_in;
   logic [idg_pkg::CMP_BITS-1:0]     ds5_ff, ds5_in;
   logic [idg_pkg::CMP_BITS-1:0]     ds25_ff, ds25_in;
   logic [idg_pkg::CMP_BITS-1:0]     ds40_ff, ds40_in;
   logic [idg_pkg::PROD_BITS-1:0]    rn_ff, rn_in;
   logic [idg_pkg::BIN_IDX_BITS-1:0] thr_ff, thr_in;
   logic [idg_pkg::BIN_IDX_BITS-1:0] bin_idx_ff, bin_idx_in;
   logic [idg_pkg::ACC_BITS-1:0]     acc_ff, acc_in;
   logic                             decision_ff, decision_in;
   logic                             out_ff, out_in;

   logic [idg_pkg::VALUE_BITS-1:0]   value;
   logic [idg_pkg::VALUE_BITS-1:0]   diff;
   logic                             first_elem;
   logic                             small_hit;
   logic [idg_pkg::SUM_BITS:0]       dsum_add;

   logic [idg_pkg::CMP_BITS-1:0]     n_x, nm1_x, rn_x, cc2_x, cc4_x, ds2_x, nm1_4_x;
   logic [idg_pkg::CMP_BITS-1:0]     acc5_x;
   logic                             w1_ok, w2_ok, rng_w1, mad25, test_a, test_b;

   always_comb begin
      numeric_in = numeric_ff;
      width_in   = width_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            idg_pkg::CSR_IS_NUMERIC:    numeric_in = csr_write_data[0];
            idg_pkg::CSR_ELEMENT_WIDTH: width_in   = csr_write_data[idg_pkg::WIDTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      value = (width_ff == idg_pkg::WIDTH_BYTE)
              ? idg_pkg::VALUE_BITS'(element_value[idg_pkg::BYTE_BITS-1:0])
              : element_value;
      diff       = (value > prev_ff) ? value - prev_ff : prev_ff - value;
      first_elem = (count_ff == '0);
      small_hit  = (diff[idg_pkg::VALUE_BITS-1:idg_pkg::BIN_IDX_BITS] == '0);
      dsum_add   = {1'b0, dsum_ff} + (idg_pkg::SUM_BITS + 1)'(diff);
   end

   always_comb begin
      count_in = count_ff;
      prev_in  = prev_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      dsum_in  = dsum_ff;
      chg_in   = chg_ff;
      for (int i = 0; i < idg_pkg::SMALL_BINS; i++) begin
         bins_in[i] = bins_ff[i];
      end
      if (cmd.finish) begin
         count_in = '0;
         prev_in  = '0;
         min_in   = '0;
         max_in   = '0;
         dsum_in  = '0;
         chg_in   = '0;
         for (int i = 0; i < idg_pkg::SMALL_BINS; i++) begin
            bins_in[i] = '0;
         end
      end else if (cmd.update) begin
         if (first_elem) begin
            min_in = value;
            max_in = value;
         end else begin
            dsum_in = dsum_add[idg_pkg::SUM_BITS] ? '1 : dsum_add[idg_pkg::SUM_BITS-1:0];
            if (diff != '0 && chg_ff != '1) begin
               chg_in = chg_ff + 1'b1;
            end
            for (int i = 0; i < idg_pkg::SMALL_BINS; i++) begin
               if (small_hit && diff[idg_pkg::BIN_IDX_BITS-1:0] == idg_pkg::BIN_IDX_BITS'(i)
                   && bins_ff[i] != '1) begin
                  bins_in[i] = bins_ff[i] + 1'b1;
               end
            end
            if (value < min_ff) begin
               min_in = value;
            end
            if (value > max_ff) begin
               max_in = value;
            end
         end
         prev_in = value;
         if (count_ff != '1) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // scale delta sum by 5, then 25 and 40, by shift and add; range*(n-1); bin sum
   always_comb begin
      range_in   = range_ff;
      nm1_in     = nm1_ff;
      ds5_in     = ds5_ff;
      ds25_in    = ds25_ff;
      ds40_in    = ds40_ff;
      rn_in      = rn_ff;
      thr_in     = thr_ff;
      bin_idx_in = bin_idx_ff;
      acc_in     = acc_ff;
      if (cmd.prep) begin
         range_in   = max_ff - min_ff;
         nm1_in     = count_ff - 1'b1;
         ds5_in     = (idg_pkg::CMP_BITS'(dsum_ff) << 2) + idg_pkg::CMP_BITS'(dsum_ff);
         bin_idx_in = '0;
         acc_in     = '0;
      end
      if (cmd.mult) begin
         rn_in   = idg_pkg::PROD_BITS'(range_ff) * idg_pkg::PROD_BITS'(nm1_ff);
         ds25_in = (ds5_ff << 2) + ds5_ff;
         ds40_in = ds5_ff << 3;
         thr_in  = (range_ff[idg_pkg::VALUE_BITS-1:idg_pkg::BYTE_BITS] != '0)
                   ? idg_pkg::BIN_IDX_BITS'(idg_pkg::SMALL_BINS - 1)
                   : range_ff[idg_pkg::BYTE_BITS-1:idg_pkg::BIN_IDX_BITS];
      end
      if (cmd.bin_step) begin
         if (bin_idx_ff <= thr_ff) begin
            acc_in = acc_ff + idg_pkg::ACC_BITS'(bins_ff[bin_idx_ff]);
         end
         bin_idx_in = bin_idx_ff + 1'b1;
      end
   end

   always_comb begin
      n_x     = idg_pkg::CMP_BITS'(count_ff);
      nm1_x   = idg_pkg::CMP_BITS'(nm1_ff);
      rn_x    = idg_pkg::CMP_BITS'(rn_ff);
      cc2_x   = idg_pkg::CMP_BITS'(chg_ff) << 1;
      cc4_x   = idg_pkg::CMP_BITS'(chg_ff) << 2;
      ds2_x   = idg_pkg::CMP_BITS'(dsum_ff) << 1;
      nm1_4_x = nm1_x << 2;
      acc5_x  = (idg_pkg::CMP_BITS'(acc_ff) << 2) + idg_pkg::CMP_BITS'(acc_ff);

      mad25  = ds25_ff < rn_x;
      rng_w1 = range_ff >= idg_pkg::VALUE_BITS'(idg_pkg::RANGE_MIN_W1);
      test_a = rng_w1 && mad25 && (cc2_x > n_x || ds2_x < nm1_x);
      test_b = rng_w1 && count_ff >= idg_pkg::COUNT_BITS'(idg_pkg::N_MIN_BINS)
               && cc4_x > n_x && acc5_x >= nm1_4_x;
      w1_ok  = width_ff == idg_pkg::WIDTH_BYTE
               && count_ff >= idg_pkg::COUNT_BITS'(idg_pkg::N_MIN_W1) && (test_a || test_b);
      w2_ok  = width_ff == idg_pkg::WIDTH_HALF
               && count_ff >= idg_pkg::COUNT_BITS'(idg_pkg::N_MIN_W2)
               && range_ff >= idg_pkg::VALUE_BITS'(idg_pkg::RANGE_MIN_W2)
               && mad25 && cc2_x > n_x
               && (range_ff >= idg_pkg::VALUE_BITS'(idg_pkg::RANGE_WIDE_W2) || ds40_ff < rn_x);

      decision_in = cmd.compare ? (numeric_ff && count_ff != '0 && (w1_ok || w2_ok))
                                : decision_ff;
      out_in      = cmd.finish ? decision_ff : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         numeric_ff <= 1'b1;
         width_ff   <= idg_pkg::WIDTH_BYTE;
         count_ff   <= '0;
         prev_ff    <= '0;
         min_ff     <= '0;
         max_ff     <= '0;
         dsum_ff    <= '0;
         chg_ff     <= '0;
         for (int i = 0; i < idg_pkg::SMALL_BINS; i++) begin
            bins_ff[i] <= '0;
         end
      end else begin
         numeric_ff <= numeric_in;
         width_ff   <= width_in;
         count_ff   <= count_in;
         prev_ff    <= prev_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         dsum_ff    <= dsum_in;
         chg_ff     <= chg_in;
         for (int i = 0; i < idg_pkg::SMALL_BINS; i++) begin
            bins_ff[i] <= bins_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      range_ff    <= range_in;
      nm1_ff      <= nm1_in;
      ds5_ff      <= ds5_in;
      ds25_ff     <= ds25_in;
      ds40_ff     <= ds40_in;
      rn_ff       <= rn_in;
      thr_ff      <= thr_in;
      bin_idx_ff  <= bin_idx_in;
      acc_ff      <= acc_in;
      decision_ff <= decision_in;
      out_ff      <= out_in;
   end

   assign status.bin_last = (bin_idx_ff == idg_pkg::BIN_IDX_BITS'(idg_pkg::SMALL_BINS - 1));
   assign choose_delta    = out_ff;

endmodule

### rtl/idg_controller.sv
// Sequencing state machine and response valid register of the delta gate.
module idg_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output idg_pkg::ctl_cmd_type   cmd,
   input  idg_pkg::dp_status_type status
);

   typedef enum logic [5:0] {
      S_RUN  = 6'b000001,
      S_PREP = 6'b000010,
      S_MULT = 6'b000100,
      S_BINS = 6'b001000,
      S_CMP  = 6'b010000,
      S_DONE = 6'b100000
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   logic          slot_free;

   assign req_ready = (state_ff == S_RUN);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_RUN: begin
            cmd.update = accept;
            if (accept && req_last) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_MULT;
         end
         S_MULT: begin
            cmd.mult = 1'b1;
            state_in = S_BINS;
         end
         S_BINS: begin
            cmd.bin_step = 1'b1;
            if (status.bin_last) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            // hold until the response register is free
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = S_RUN;
            end
         end
         default: state_in = S_RUN;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/index_stream_delta_gate.sv
// Top level of the index stream delta gate: controller, datapath and channel wiring.
// The gate takes one element request per cycle while a stream runs and gathers count,
// min/max, previous value, absolute delta sum, change count and sixteen small-delta
// counters. The request carrying the last element starts the decision sequence:
// forming range and n-1, the 16x32 range*(n-1) multiply, stepping the small-delta
// counters through one adder, a compare step and loading the response register, so req
// ready stays low from a last element until the sequence ends. The statistics are
// cleared as the response is loaded, so the next stream may start while the decision
// waits to be taken; a further last element then waits in the final step until the
// response register is free. Configuration is to be written while idle (not enforced).
module index_stream_delta_gate (
   input  logic                               clock,
   input  logic                               reset,
   idg_req_if.sink                            req_stream,
   idg_rsp_if.source                          rsp_stream,
   input  logic                               csr_write_enable,
   input  logic [idg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [idg_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   idg_pkg::ctl_cmd_type   cmd;
   idg_pkg::dp_status_type status;
   logic                   req_ready;
   logic                   rsp_valid;
   logic                   choose_delta;

   idg_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_stream.valid),
      .req_last  (req_stream.last_element),
      .req_ready (req_ready),
      .rsp_ready (rsp_stream.ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   idg_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .element_value    (req_stream.element_value),
      .choose_delta     (choose_delta)
   );

   assign req_stream.ready        = req_ready;
   assign rsp_stream.valid        = rsp_valid;
   assign rsp_stream.choose_delta = choose_delta;

endmodule

### rtl/idg_checker.sv
// Port-level assertions for the index stream delta gate and their bind.
module idg_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_choose_delta
);

   logic req_accept;
   assign req_accept = req_valid && req_ready;

   rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   rsp_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_choose_delta))
      else $error("response payload changed while stalled");

   last_blocks_req: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last |=> !req_ready ##1 !req_ready)
      else $error("request taken during decision sequence");

   rsp_after_decision: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised outside the decision sequence");

endmodule

bind index_stream_delta_gate idg_checker u_idg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_stream.valid),
   .req_ready        (req_stream.ready),
   .req_last         (req_stream.last_element),
   .rsp_valid        (rsp_stream.valid),
   .rsp_ready        (rsp_stream.ready),
   .rsp_choose_delta (rsp_stream.choose_delta)
);

### sim/tb.sv
// Testbench for the index stream delta gate: directed and random element streams.
module tb;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS  = 950;
   localparam longint unsigned SUM_LIMIT = (64'd1 << idg_pkg::SUM_BITS) - 64'd1;

   typedef enum int {SHAPE_NOISE, SHAPE_WALK, SHAPE_STEP, SHAPE_ROUGH} stream_shape_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_write_enable;
   logic [idg_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [idg_pkg::CSR_DATA_BITS-1:0]  csr_write_data;

   idg_req_if req_stream ();
   idg_rsp_if rsp_stream ();

   index_stream_delta_gate dut (
      .clock            (clock),
      .reset            (reset),
      .req_stream       (req_stream),
      .rsp_stream       (rsp_stream),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   bit                           cfg_numeric;
   bit [idg_pkg::WIDTH_BITS-1:0] cfg_width;
   bit [idg_pkg::COUNT_BITS-1:0] seen_count;
   bit [idg_pkg::VALUE_BITS-1:0] prev_value;
   bit [idg_pkg::VALUE_BITS-1:0] low_value;
   bit [idg_pkg::VALUE_BITS-1:0] high_value;
   bit [idg_pkg::SUM_BITS-1:0]   delta_total;
   bit [idg_pkg::CHG_BITS-1:0]   change_total;
   bit [idg_pkg::BIN_BITS-1:0]   small_bins [idg_pkg::SMALL_BINS];
   bit                           decision_q [$];
   bit                           want_delta;
   bit                           idling_on;
   int                           hold_cycles;
   int                           fail_count;
   int                           cycle_count;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void clear_stats();
      seen_count   = '0;
      prev_value   = '0;
      low_value    = '0;
      high_value   = '0;
      delta_total  = '0;
      change_total = '0;
      foreach (small_bins[i]) small_bins[i] = '0;
   endfunction

   function automatic bit delta_verdict();
      longint unsigned n, nm1, rng, rng_n, dsum, chg, small_total;
      int thr;
      n    = seen_count;
      dsum = delta_total;
      chg  = change_total;
      if (!cfg_numeric || n == 0) return 1'b0;
      rng   = high_value - low_value;
      nm1   = n - 1;
      rng_n = rng * nm1;
      if (cfg_width == idg_pkg::WIDTH_BYTE && n >= idg_pkg::N_MIN_W1) begin
         if (rng >= idg_pkg::RANGE_MIN_W1 && dsum * 25 < rng_n
             && (chg * 2 > n || dsum * 2 < nm1))
            return 1'b1;
         if (rng >= idg_pkg::RANGE_MIN_W1 && n >= idg_pkg::N_MIN_BINS && chg * 4 > n) begin
            thr = (rng / 16 > idg_pkg::SMALL_BINS - 1) ? idg_pkg::SMALL_BINS - 1
                                                       : int'(rng / 16);
            small_total = 0;
            for (int i = 0; i <= thr; i++) small_total += small_bins[i];
            if (small_total * 5 >= nm1 * 4) return 1'b1;
         end
      end
      if (cfg_width == idg_pkg::WIDTH_HALF && n >= idg_pkg::N_MIN_W2
          && rng >= idg_pkg::RANGE_MIN_W2 && dsum * 25 < rng_n
          && chg * 2 > n && (rng >= idg_pkg::RANGE_WIDE_W2 || dsum * 40 < rng_n))
         return 1'b1;
      return 1'b0;
   endfunction

   function automatic void track_element(logic [idg_pkg::VALUE_BITS-1:0] value, logic is_last);
      bit [idg_pkg::VALUE_BITS-1:0] v;
      bit [idg_pkg::VALUE_BITS-1:0] d;
      longint unsigned              total;
      v = value;
      if (cfg_width == idg_pkg::WIDTH_BYTE) v[idg_pkg::VALUE_BITS-1:idg_pkg::BYTE_BITS] = '0;
      if (seen_count == 0) begin
         low_value  = v;
         high_value = v;
      end else begin
         d = (v > prev_value) ? v - prev_value : prev_value - v;
         total = delta_total;
         total += d;
         delta_total = (total > SUM_LIMIT) ? SUM_LIMIT : total;
         if (d != 0 && ~&change_total) change_total++;
         if (d < idg_pkg::SMALL_BINS && ~&small_bins[d]) small_bins[d]++;
         if (v < low_value) low_value = v;
         if (v > high_value) high_value = v;
      end
      prev_value = v;
      if (~&seen_count) seen_count++;
      if (is_last) begin
         decision_q.push_back(delta_verdict());
         clear_stats();
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      fail_count++;
   endtask

   task automatic send_element(input logic [idg_pkg::VALUE_BITS-1:0] value,
                               input logic is_last);
      int gap;
      gap = idling_on ? $urandom_range(0, 3) : 0;
      repeat (gap) begin
         req_stream.valid <= 1'b0;
         @(posedge clock);
      end
      req_stream.valid         <= 1'b1;
      req_stream.element_value <= value;
      req_stream.last_element  <= is_last;
      do @(posedge clock); while (!req_stream.ready);
      track_element(value, is_last);
   endtask

   task automatic wait_drained();
      while (decision_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(input logic [idg_pkg::CSR_DATA_BITS-1:0] numeric_data,
                               input logic [idg_pkg::CSR_DATA_BITS-1:0] width_data);
      req_stream.valid <= 1'b0;
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index        <= idg_pkg::CSR_IS_NUMERIC;
      csr_write_data   <= numeric_data;
      @(posedge clock);
      cfg_numeric = numeric_data[0];
      csr_index      <= idg_pkg::CSR_ELEMENT_WIDTH;
      csr_write_data <= width_data;
      @(posedge clock);
      cfg_width = width_data;
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_directed_cases();
      // reset defaults: numeric, one byte per element
      send_element(16'hFFFF, 1'b1);
      send_element(16'h0000, 1'b0);
      send_element(16'hFFFF, 1'b1);
      apply_config(4'b1110, idg_pkg::WIDTH_HALF);
      send_element(16'hFFFF, 1'b0);
      send_element(16'h0000, 1'b1);
      apply_config(4'b0001, 4'd0);
      send_element(16'h5A5A, 1'b1);
      apply_config(4'b1111, 4'd15);
      send_element(16'hA5A5, 1'b0);
      send_element(16'h0001, 1'b1);
      apply_config(4'b0001, 4'd8);
      send_element(16'h7FFF, 1'b1);
      apply_config(4'b0001, idg_pkg::WIDTH_HALF);
      send_element(16'h8000, 1'b0);
      send_element(16'h7FFF, 1'b0);
      send_element(16'hFFFF, 1'b1);
   endtask

   task automatic test_width_change_mid_stream();
      apply_config(4'b0001, idg_pkg::WIDTH_HALF);
      send_element(16'h12F0, 1'b0);
      send_element(16'hFF01, 1'b0);
      apply_config(4'b0001, idg_pkg::WIDTH_BYTE);
      send_element(16'hABCD, 1'b0);
      send_element(16'h0102, 1'b1);
      send_element(16'hFFFF, 1'b0);
      apply_config(4'b0001, idg_pkg::WIDTH_HALF);
      send_element(16'h1234, 1'b1);
   endtask

   task automatic test_random_streams();
      int                           items, streams, len, walk, stride, jump, jump_at, pick;
      bit                           rising;
      stream_shape_type             shape;
      logic [idg_pkg::VALUE_BITS-1:0] value;
      items   = 0;
      streams = 0;
      while (items < RANDOM_ITEMS) begin
         if (streams % 4 == 0) begin
            pick = $urandom_range(0, 9);
            if (pick <= 4)
               apply_config({3'($urandom_range(0, 7)), 1'b1}, idg_pkg::WIDTH_BYTE);
            else if (pick <= 6)
               apply_config({3'($urandom_range(0, 7)), 1'b1}, idg_pkg::WIDTH_HALF);
            else if (pick == 7)
               apply_config({3'($urandom_range(0, 7)), 1'b0}, 4'($urandom_range(0, 15)));
            else if (pick == 8) apply_config(4'b0001, 4'($urandom_range(0, 15)));
            else apply_config(4'($urandom_range(0, 15)), idg_pkg::WIDTH_BYTE);
         end
         idling_on = ($urandom_range(0, 5) != 0);
         pick = $urandom_range(0, 9);
         if (pick <= 3) begin
            shape = SHAPE_NOISE;
            len   = $urandom_range(1, 12);
         end else if (pick <= 6) begin
            shape = SHAPE_WALK;
            len   = $urandom_range(64, 200);
         end else if (pick <= 8) begin
            shape = SHAPE_STEP;
            len   = $urandom_range(150, 250);
         end else begin
            shape = SHAPE_ROUGH;
            len   = $urandom_range(20, 160);
         end
         walk    = (shape == SHAPE_STEP) ? $urandom_range(0, 150) : $urandom_range(0, 255);
         jump    = $urandom_range(64, 100);
         jump_at = $urandom_range(0, len - 1);
         rising  = $urandom_range(0, 1);
         for (int k = 0; k < len; k++) begin
            case (shape)
               SHAPE_NOISE: value = 16'($urandom);
               SHAPE_STEP: begin
                  if (k == jump_at) walk = walk + jump;
                  value = {8'($urandom), 8'(walk)};
               end
               default: begin
                  stride = $urandom_range(0, 2);
                  if ($urandom_range(0, 19) == 0) rising = !rising;
                  if (rising && walk + stride > 255) rising = 1'b0;
                  if (!rising && walk < stride) rising = 1'b1;
                  walk  = rising ? walk + stride : walk - stride;
                  value = {8'($urandom), 8'(walk)};
                  if (shape == SHAPE_ROUGH && $urandom_range(0, 9) == 0) value = 16'($urandom);
               end
            endcase
            send_element(value, k == len - 1);
         end
         items += len;
         streams++;
      end
      idling_on = 1'b1;
   endtask

   task automatic test_full_backpressure();
      apply_config(4'b0001, idg_pkg::WIDTH_BYTE);
      idling_on   = 1'b1;
      hold_cycles = 400;
      // keep offering short streams while the response side holds off
      for (int s = 0; s < 4; s++) begin
         send_element(16'($urandom), 1'b0);
         send_element(16'($urandom), 1'b0);
         send_element(16'($urandom), 1'b1);
      end
   endtask

   initial begin : response_taker
      int wait_cycles;
      rsp_stream.ready <= 1'b0;
      forever begin
         wait_cycles = idling_on ? $urandom_range(0, 3) : 0;
         if (hold_cycles > 0) begin
            wait_cycles = hold_cycles;
            hold_cycles = 0;
         end
         repeat (wait_cycles) begin
            rsp_stream.ready <= 1'b0;
            @(posedge clock);
         end
         rsp_stream.ready <= 1'b1;
         do @(posedge clock); while (!rsp_stream.valid && hold_cycles == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_stream.valid && rsp_stream.ready) begin
         if (decision_q.size() == 0) begin
            report_mismatch("response with no stream pending");
         end else begin
            want_delta = decision_q.pop_front();
            if (rsp_stream.choose_delta !== want_delta)
               report_mismatch($sformatf("choose_delta got %b want %b",
                                         rsp_stream.choose_delta, want_delta));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      req_stream.valid         <= 1'b0;
      req_stream.element_value <= '0;
      req_stream.last_element  <= 1'b0;
      csr_write_enable         <= 1'b0;
      csr_index                <= idg_pkg::CSR_IS_NUMERIC;
      csr_write_data           <= '0;
      cfg_numeric = 1'b1;
      cfg_width   = idg_pkg::WIDTH_BYTE;
      clear_stats();
      idling_on = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_width_change_mid_stream();
      test_random_streams();
      test_full_backpressure();
      req_stream.valid <= 1'b0;
      wait_drained();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
